@@ src/gsv_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and table generators for the grain voice pool.
package gsv_pkg;

  // Pool size and table resolution
  localparam int VOICES     = 64;
  localparam int TABLE_BITS = 10;
  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int VOICE_AW   = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Widths of the mix path: a grain term is 17 bits signed
  localparam int TERM_W = 17;
  localparam int ACC_W  = TERM_W + VOICE_AW + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP_PER_FREQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STEP_NUMER    = 2'd2;

  localparam logic [14:0] THRESHOLD_RESET = 15'd29491;
  localparam logic [31:0] PSTEP_RESET     = 32'd366503875;
  localparam logic [31:0] WNUM_RESET      = 32'd89478485;

  localparam logic signed [63:0] MIX_MAX = 64'sd8388607;
  localparam logic signed [63:0] MIX_MIN = -64'sd8388608;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [63:0] ONE_Q30 = 64'sh4000_0000;

  // Per-voice state held in the voice RAM
  typedef struct packed {
    logic [31:0] sine_phase;
    logic [31:0] sine_step;
    logic [31:0] window_phase;
    logic [31:0] window_step;
  } voice_t;

  // Each table word holds entry k and entry k+1 (wrapped): {v0, v1}
  typedef logic [31:0] pair_tab_t [TABLE_SIZE];
  typedef logic signed [15:0] tab_t [TABLE_SIZE];

  // sin(2*pi*p/2^32) in Q30, Taylor series on a quarter wave
  function automatic logic signed [63:0] sin_q30(input logic [31:0] p);
    logic [1:0]  quad;
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    quad = p[31:30];
    q = {34'd0, p[29:0]};
    if (quad[0]) q = 64'h4000_0000 - q;
    x = (q * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    sum = $signed(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - $signed(term);
    return quad[1] ? -sum : sum;
  endfunction

  // Build the sine or Hann table as neighbor pairs
  function automatic pair_tab_t make_pair_table(input logic is_window);
    tab_t tab;
    pair_tab_t pairs;
    logic [31:0] p;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic signed [63:0] w30;
    logic [63:0] mag;
    logic [63:0] v15;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      p = 32'(k) << (32 - TABLE_BITS);
      if (is_window) begin
        c = sin_q30(p + 32'h4000_0000);
        w30 = ONE_Q30 - c;
        if (w30 < 0) w30 = 0;
        v15 = ($unsigned(w30) + 64'd32768) >> 16;
        if (v15 > 64'd32767) v15 = 64'd32767;
        tab[k] = 16'(v15);
      end else begin
        s = sin_q30(p);
        mag = (s < 0) ? $unsigned(-s) : $unsigned(s);
        v15 = (mag + 64'd16384) >> 15;
        if (v15 > 64'd32767) v15 = 64'd32767;
        tab[k] = (s < 0) ? -16'(v15) : 16'(v15);
      end
    end
    for (int k = 0; k < TABLE_SIZE; k++) begin
      pairs[k] = {tab[k], tab[(k + 1) % TABLE_SIZE]};
    end
    return pairs;
  endfunction

endpackage

@@ src/windowed_sine_grain_voice_pool.sv @@
`timescale 1ns / 1ps
// Granular voice pool top level: sequencer, voice RAM sweep and mix pipeline.
//
// One audio sample is one input transaction and gives one output transaction.
// The block walks all voice slots of the voice RAM, one slot per cycle through
// its single read port, followed by a pipeline drain, which lasts longer when
// one of the last slots holds an active voice. A sample with a rising trigger
// first runs the serial divider that forms the window step. This also happens
// when the pool is full. The next sample is taken in the cycle after the
// result has been loaded, once the previous sweep has finished; the finished
// mix waits in the output register. After reset the sine and Hann tables are
// loaded into their RAMs in a pass over all TABLE_SIZE (1024) entries, during
// which no sample is taken; configuration writes are accepted at any time the
// block is idle.
module windowed_sine_grain_voice_pool (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gsv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gsv_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [15:0]                   in_trigger_level,
  input  logic [19:0]                          in_frequency,
  input  logic [15:0]                          in_duration_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [23:0]                   out_mix_sample
);

  import gsv_pkg::*;

  localparam pair_tab_t SINE_PAIRS = make_pair_table(1'b0);
  localparam pair_tab_t WIN_PAIRS  = make_pair_table(1'b1);

  typedef enum logic [5:0] {
    S_FILL  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_SWEEP = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [14:0] thr_r;
  logic [31:0] pstep_r;
  logic [31:0] wnum_r;
  logic [15:0] prev_trig_r;
  logic [TABLE_BITS-1:0] fill_r;
  logic [VOICE_AW-1:0]   vc_r;
  logic [VOICES-1:0]     active_r;
  logic        claim_pend_r;
  logic [31:0] sstep_r;
  logic [31:0] wstep_r;
  logic signed [ACC_W-1:0] acc_r;
  logic        out_valid_r;
  logic signed [23:0] out_mix_r;

  logic in_fire, trig_fire, out_free, div_done, claim_take, s0_act, pipe_busy;
  logic [31:0] div_quot;
  logic [51:0] sprod;

  // Pipeline registers
  logic p1_act_r, p1_claim_r;
  logic [VOICE_AW-1:0] p1_idx_r;
  logic p2_act_r;
  logic [15:0] p2_fw_r, p2_fs_r;
  logic p3_act_r;
  logic signed [15:0] p3_w0_r, p3_s0_r;
  logic signed [33:0] p3_pw_r, p3_ps_r;
  logic p4_act_r;
  logic signed [31:0] p4_prod_r;

  // Memory ports
  logic [$bits(voice_t)-1:0] vram_rdata;
  voice_t vdat, vwb;
  logic [31:0] sine_rdata, win_rdata;
  logic [TABLE_BITS-1:0] widx, sidx;
  logic [31:0] nsp, nwp;
  logic wcarry;

  // Stage 2 and 3 combinational
  logic signed [15:0] w0, w1, s0, s1;
  logic signed [16:0] dw, ds;
  logic signed [17:0] wsum, ssum;
  logic signed [15:0] wv, sv;
  logic signed [TERM_W-1:0] term;
  logic signed [63:0] acc_ext;
  logic signed [23:0] mix_sat;

  // Handshake
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign trig_fire = (prev_trig_r == 16'd0) &&
                     (in_trigger_level > $signed({1'b0, thr_r})) &&
                     (in_frequency != 20'd0) && (in_duration_ms != 16'd0);
  assign sprod     = 52'(in_frequency) * 52'(pstep_r);
  assign pipe_busy = p1_act_r || p2_act_r || p3_act_r || p4_act_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RESET;
      pstep_r <= PSTEP_RESET;
      wnum_r  <= WNUM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIGGER_THRESHOLD:   thr_r   <= cfg_wdata[14:0];
        CFG_PHASE_STEP_PER_FREQ: pstep_r <= cfg_wdata[31:0];
        CFG_WINDOW_STEP_NUMER:   wnum_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Window step divider
  gsv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire && trig_fire),
    .num   (wnum_r),
    .den   (in_duration_ms),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL:  if (fill_r == TABLE_BITS'(TABLE_SIZE - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = trig_fire ? S_DIV : S_SWEEP;
      S_DIV:   if (div_done) state_nxt = S_SWEEP;
      S_SWEEP: if (vc_r == VOICE_AW'(VOICES - 1)) state_nxt = S_DRAIN;
      S_DRAIN: if (!pipe_busy) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_FILL;
    endcase
  end

  // Stage 0: slot scan and claim of the lowest free voice
  assign claim_take = (state_r == S_SWEEP) && claim_pend_r && !active_r[vc_r];
  assign s0_act     = (state_r == S_SWEEP) && (active_r[vc_r] || claim_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      fill_r       <= '0;
      vc_r         <= '0;
      active_r     <= '0;
      claim_pend_r <= 1'b0;
      prev_trig_r  <= '0;
      out_valid_r  <= 1'b0;
      p1_act_r     <= 1'b0;
      p2_act_r     <= 1'b0;
      p3_act_r     <= 1'b0;
      p4_act_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FILL) fill_r <= fill_r + 1'b1;
      if (in_fire) begin
        prev_trig_r  <= in_trigger_level;
        claim_pend_r <= trig_fire;
        vc_r         <= '0;
      end else if (state_r == S_SWEEP) begin
        vc_r <= vc_r + 1'b1;
        if (claim_take) claim_pend_r <= 1'b0;
      end
      // A grain that wraps its window frees the voice
      if (p1_act_r) active_r[p1_idx_r] <= !wcarry;
      p1_act_r <= s0_act;
      p2_act_r <= p1_act_r;
      p3_act_r <= p2_act_r;
      p4_act_r <= p3_act_r;
      // Output register
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sstep_r <= sprod[47:16];
      acc_r   <= '0;
    end else if (p4_act_r) begin
      acc_r <= acc_r + ACC_W'(term);
    end
    if (state_r == S_DIV && div_done) wstep_r <= div_quot;
    p1_idx_r   <= vc_r;
    p1_claim_r <= claim_take;
    if (state_r == S_DONE && out_free) out_mix_r <= mix_sat;
  end

  // Voice state RAM
  gsv_ram #(.WIDTH($bits(voice_t)), .DEPTH(VOICES)) u_voice_ram (
    .clk   (clk),
    .we    (p1_act_r),
    .waddr (p1_idx_r),
    .wdata (vwb),
    .raddr (vc_r),
    .rdata (vram_rdata)
  );

  // Stage 1: advance phases, write back, address the tables
  always_comb begin
    if (p1_claim_r) begin
      vdat = '{sine_phase: 32'd0, sine_step: sstep_r,
               window_phase: 32'd0, window_step: wstep_r};
    end else begin
      vdat = voice_t'(vram_rdata);
    end
    nsp = vdat.sine_phase + vdat.sine_step;
    {wcarry, nwp} = {1'b0, vdat.window_phase} + {1'b0, vdat.window_step};
    if (wcarry) vwb = '0;
    else vwb = '{sine_phase: nsp, sine_step: vdat.sine_step,
                 window_phase: nwp, window_step: vdat.window_step};
    widx = vdat.window_phase[31 -: TABLE_BITS];
    sidx = vdat.sine_phase[31 -: TABLE_BITS];
  end

  always_ff @(posedge clk) begin
    p2_fw_r <= vdat.window_phase[31-TABLE_BITS -: 16];
    p2_fs_r <= vdat.sine_phase[31-TABLE_BITS -: 16];
  end

  // Table RAMs, loaded once after reset
  gsv_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_sine_rom (
    .clk   (clk),
    .we    (state_r == S_FILL),
    .waddr (fill_r),
    .wdata (SINE_PAIRS[fill_r]),
    .raddr (sidx),
    .rdata (sine_rdata)
  );

  gsv_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_win_rom (
    .clk   (clk),
    .we    (state_r == S_FILL),
    .waddr (fill_r),
    .wdata (WIN_PAIRS[fill_r]),
    .raddr (widx),
    .rdata (win_rdata)
  );

  // Stage 2: interpolation slopes times fractions
  assign w0 = win_rdata[31:16];
  assign w1 = win_rdata[15:0];
  assign s0 = sine_rdata[31:16];
  assign s1 = sine_rdata[15:0];
  assign dw = 17'(w1) - 17'(w0);
  assign ds = 17'(s1) - 17'(s0);

  always_ff @(posedge clk) begin
    p3_w0_r <= w0;
    p3_s0_r <= s0;
    p3_pw_r <= 34'(dw) * $signed({18'd0, p2_fw_r});
    p3_ps_r <= 34'(ds) * $signed({18'd0, p2_fs_r});
  end

  // Stage 3: finish interpolation, window times sine
  assign wsum = 18'(p3_w0_r) + 18'(p3_pw_r >>> 16);
  assign ssum = 18'(p3_s0_r) + 18'(p3_ps_r >>> 16);
  assign wv   = wsum[15:0];
  assign sv   = ssum[15:0];

  always_ff @(posedge clk) begin
    p4_prod_r <= 32'(wv) * 32'(sv);
  end

  // Stage 4: grain term and mix saturation
  assign term    = TERM_W'(p4_prod_r >>> 15);
  assign acc_ext = 64'(acc_r);
  always_comb begin
    if (acc_ext > MIX_MAX) mix_sat = 24'(MIX_MAX);
    else if (acc_ext < MIX_MIN) mix_sat = 24'(MIX_MIN);
    else mix_sat = 24'(acc_ext);
  end

  assign out_valid      = out_valid_r;
  assign out_mix_sample = out_mix_r;

`ifndef SYNTHESIS
  // A voice written back is never the slot being read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_act_r && state_r == S_SWEEP) |-> (p1_idx_r != vc_r))
    else $error("voice RAM read and write hit the same slot");

  // At most one voice is claimed per sample
  a_single_claim: assert property (@(posedge clk) disable iff (!rst_n)
    claim_take |=> !claim_pend_r)
    else $error("claim still pending after a voice was taken");

  // The divider only finishes while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider result arrived outside the divide state");
`endif

endmodule

@@ src/gsv_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module gsv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/gsv_div.sv @@
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle, for the window step.
module gsv_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [31:0] quot
);

  logic [16:0] rem_r;
  logic [31:0] q_r;
  logic [15:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] rem_sh;
  logic        fits;

  // One trial subtraction per cycle
  assign rem_sh = {rem_r[15:0], q_r[31]};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
      q_r   <= {q_r[30:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
